// ----- rtl/epoch_utc_pkg.sv -----
// Types and constants for the microsecond-epoch to UTC calendar converter.
// Depends on nothing; used by epoch_microseconds_to_utc_fields.

package epoch_utc_pkg;

   // Number of register stages from the accepting edge to the result registers.
   localparam int NUM_STAGES = 18;

   // First microsecond count at or beyond 10000-01-01 00:00:00 UTC.
   localparam logic [57:0] US_LIMIT = 58'd253402300800000000;

   // One million is 64 times 15625: the low six bits pass straight to the fraction.
   localparam int          US_LOW_BITS  = 6;
   localparam logic [13:0] DIV_15625    = 14'd15625;
   localparam logic [31:0] RCP_15625    = 32'd2251799814;
   localparam int          SHR_15625    = 45;

   // 86400 is 128 times 675.
   localparam int          DAY_LOW_BITS = 7;
   localparam logic [31:0] RCP_675      = 32'd3257812231;
   localparam int          SHR_675      = 41;
   localparam logic [16:0] SEC_PER_DAY  = 17'd86400;

   localparam logic [21:0] DAY_OFFSET   = 22'd719468;
   localparam logic [17:0] DAYS_PER_ERA = 18'd146097;
   localparam logic [22:0] RCP_146097   = 23'd7525902;
   localparam int          SHR_146097   = 40;
   localparam logic [17:0] DOE_LAST     = 18'd146096;

   localparam logic [11:0] SEC_PER_HOUR = 12'd3600;
   localparam logic [17:0] RCP_3600     = 18'd149131;
   localparam int          SHR_3600     = 29;

   localparam logic [5:0]  SEC_PER_MIN  = 6'd60;
   localparam logic [12:0] RCP_60       = 13'd4370;
   localparam int          SHR_60       = 18;

   localparam logic [18:0] RCP_1460     = 19'd367720;
   localparam int          SHR_1460     = 29;
   localparam logic [18:0] RCP_36524    = 19'd470373;
   localparam int          SHR_36524    = 34;
   localparam logic [18:0] RCP_365      = 19'd367720;
   localparam int          SHR_365      = 27;

   // Division by 100 for the year of era (9 bits) and for the full year (14 bits).
   localparam logic [9:0]  RCP_100_YOE  = 10'd656;
   localparam int          SHR_100_YOE  = 16;
   localparam logic [14:0] RCP_100_YEAR = 15'd20972;
   localparam int          SHR_100_YEAR = 21;
   localparam logic [6:0]  CENTURY      = 7'd100;

   localparam logic [8:0]  DAYS_PER_YEAR = 9'd365;
   localparam logic [8:0]  YEARS_PER_ERA = 9'd400;
   localparam logic [8:0]  MARCH_TO_JAN  = 9'd306;
   localparam logic [8:0]  JAN_FEB_DAYS  = 9'd59;
   localparam logic [13:0] YEAR_BASE     = 14'd1900;

   typedef struct packed {
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic [19:0] micro;
   } tod_type;

   typedef struct packed {
      logic        rng;
      logic [5:0]  low6;
      logic [51:0] n;
   } st1_type;

   typedef struct packed {
      logic        rng;
      logic [5:0]  low6;
      logic [4:0]  q1;
      logic [17:0] x1;
      logic [33:0] nlow;
   } st2_type;

   typedef struct packed {
      logic        rng;
      logic [5:0]  low6;
      logic [4:0]  q1;
      logic [13:0] r1;
      logic [33:0] nlow;
   } st3_type;

   typedef struct packed {
      logic        rng;
      logic [5:0]  low6;
      logic [4:0]  q1;
      logic [16:0] q2;
      logic [30:0] x2;
      logic [16:0] n3;
   } st4_type;

   typedef struct packed {
      logic        rng;
      logic [5:0]  low6;
      logic [4:0]  q1;
      logic [16:0] q2;
      logic [13:0] r2;
      logic [16:0] n3;
   } st5_type;

   typedef struct packed {
      logic        rng;
      logic [5:0]  low6;
      logic [21:0] hi;
      logic [16:0] q3;
      logic [30:0] x3;
   } st6_type;

   typedef struct packed {
      logic        rng;
      logic [19:0] frac;
      logic [37:0] secs;
   } st7_type;

   typedef struct packed {
      logic        rng;
      logic [19:0] frac;
      logic [37:0] secs;
      logic [21:0] days;
   } st8_type;

   typedef struct packed {
      logic        rng;
      logic [19:0] frac;
      logic [16:0] sod;
      logic [21:0] z;
   } st9_type;

   typedef struct packed {
      logic        rng;
      logic [19:0] frac;
      logic [16:0] sod;
      logic [4:0]  hour;
      logic [21:0] z;
      logic [4:0]  era;
   } st10_type;

   typedef struct packed {
      logic        rng;
      logic [19:0] frac;
      logic [4:0]  hour;
      logic [11:0] remh;
      logic [4:0]  era;
      logic [17:0] doe;
   } st11_type;

   typedef struct packed {
      logic        rng;
      logic [19:0] frac;
      logic [4:0]  hour;
      logic [11:0] remh;
      logic [5:0]  minute;
      logic [4:0]  era;
      logic [17:0] doe;
      logic [6:0]  a;
      logic [2:0]  b;
      logic        c;
   } st12_type;

   typedef struct packed {
      logic        rng;
      tod_type     tod;
      logic [4:0]  era;
      logic [17:0] doe;
      logic [17:0] t;
   } st13_type;

   typedef struct packed {
      logic        rng;
      tod_type     tod;
      logic [4:0]  era;
      logic [17:0] doe;
      logic [8:0]  yoe;
   } st14_type;

   typedef struct packed {
      logic        rng;
      tod_type     tod;
      logic [17:0] doe;
      logic [17:0] p365;
      logic [6:0]  y4;
      logic [1:0]  y100;
      logic [13:0] year;
   } st15_type;

   typedef struct packed {
      logic        rng;
      tod_type     tod;
      logic [8:0]  doy;
      logic [13:0] year;
   } st16_type;

   typedef struct packed {
      logic        rng;
      tod_type     tod;
      logic [8:0]  doy;
      logic [13:0] year;
      logic [6:0]  q100;
   } st17_type;

   typedef struct packed {
      logic        rng;
      logic [12:0] years;
      logic [8:0]  yday;
      tod_type     tod;
   } rsp_type;

endpackage

// ----- rtl/epoch_microseconds_to_utc_fields.sv -----
// UTC calendar fields from a microsecond count since 1970-01-01; uses epoch_utc_pkg.
// Each accepted item shows its result with rsp_valid high for a single cycle, after
// it has passed all 18 register stages, the result registers counting as the last.
// Throughput: one item per cycle, set by the 18-stage pipeline; nothing ever stalls it.
// Reset clears every stage valid bit and holds busy high for the cycle after reset.
// The receiver cannot stall, so busy is low at all other times.

module epoch_microseconds_to_utc_fields (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [57:0] req_epoch_microseconds,
   output logic        rsp_valid,
   output logic [12:0] rsp_years_since_1900,
   output logic [8:0]  rsp_day_of_year,
   output logic [4:0]  rsp_hour_of_day,
   output logic [5:0]  rsp_minute_of_hour,
   output logic [5:0]  rsp_whole_seconds,
   output logic [19:0] rsp_microsecond_part,
   output logic        rsp_range_error
);

   localparam int NS = epoch_utc_pkg::NUM_STAGES;

   // Control: one valid bit per stage, shifted along with the data.
   logic          busy_ff, busy_in;
   logic          accept;
   logic [NS-1:0] vld_ff, vld_in;

   // Payload registers of each stage (no reset needed).
   epoch_utc_pkg::st1_type  st1_ff,  st1_in;
   epoch_utc_pkg::st2_type  st2_ff,  st2_in;
   epoch_utc_pkg::st3_type  st3_ff,  st3_in;
   epoch_utc_pkg::st4_type  st4_ff,  st4_in;
   epoch_utc_pkg::st5_type  st5_ff,  st5_in;
   epoch_utc_pkg::st6_type  st6_ff,  st6_in;
   epoch_utc_pkg::st7_type  st7_ff,  st7_in;
   epoch_utc_pkg::st8_type  st8_ff,  st8_in;
   epoch_utc_pkg::st9_type  st9_ff,  st9_in;
   epoch_utc_pkg::st10_type st10_ff, st10_in;
   epoch_utc_pkg::st11_type st11_ff, st11_in;
   epoch_utc_pkg::st12_type st12_ff, st12_in;
   epoch_utc_pkg::st13_type st13_ff, st13_in;
   epoch_utc_pkg::st14_type st14_ff, st14_in;
   epoch_utc_pkg::st15_type st15_ff, st15_in;
   epoch_utc_pkg::st16_type st16_ff, st16_in;
   epoch_utc_pkg::st17_type st17_ff, st17_in;
   epoch_utc_pkg::rsp_type  out_ff,  out_in;

   // Combinational intermediates.
   logic [62:0] prod2, prod4, prod6, prod8;
   logic [17:0] rem3;
   logic [30:0] x2, x3, rem5, rem7;
   logic [38:0] quo7;
   logic [37:0] sod9;
   logic [44:0] prod10_era;
   logic [34:0] prod10_hour;
   logic [21:0] doe11;
   logic [16:0] remh11;
   logic [36:0] prod12_a, prod12_b, prod14;
   logic [24:0] prod12_m;
   logic [11:0] sec13;
   logic [18:0] prod15;
   logic [17:0] doy16;
   logic [28:0] prod17;
   logic        div100, leap, jan;
   logic [13:0] year18;
   logic [8:0]  yday18;

   // The block never holds an item off, so busy only covers the cycle after reset.
   assign busy_in = reset;
   assign accept  = start && !busy_ff;
   assign vld_in  = {vld_ff[NS-2:0], accept};

   always_ff @(posedge clock) begin
      busy_ff <= busy_in;
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // Stage 1: register the count, flag it if it lies past year 9999, and split off
   // the six low bits (one million is 64 times 15625).
   always_comb begin
      st1_in.rng  = (req_epoch_microseconds >= epoch_utc_pkg::US_LIMIT);
      st1_in.low6 = req_epoch_microseconds[epoch_utc_pkg::US_LOW_BITS-1:0];
      st1_in.n    = req_epoch_microseconds[57:epoch_utc_pkg::US_LOW_BITS];
   end

   // Stages 2 to 7: long division of the 52-bit count by 15625 in three chunks
   // (18, 17 and 17 bits). Each chunk takes two stages: an exact reciprocal
   // multiply gives the quotient digit, then the remainder is formed and carried
   // in front of the next chunk.
   always_comb begin
      prod2       = 63'(st1_ff.n[51:34]) * 63'(epoch_utc_pkg::RCP_15625);
      st2_in.rng  = st1_ff.rng;
      st2_in.low6 = st1_ff.low6;
      st2_in.q1   = prod2[epoch_utc_pkg::SHR_15625 +: 5];
      st2_in.x1   = st1_ff.n[51:34];
      st2_in.nlow = st1_ff.n[33:0];
   end

   always_comb begin
      rem3        = st2_ff.x1 - 18'(st2_ff.q1) * 18'(epoch_utc_pkg::DIV_15625);
      st3_in.rng  = st2_ff.rng;
      st3_in.low6 = st2_ff.low6;
      st3_in.q1   = st2_ff.q1;
      st3_in.r1   = rem3[13:0];
      st3_in.nlow = st2_ff.nlow;
   end

   always_comb begin
      x2          = {st3_ff.r1, st3_ff.nlow[33:17]};
      prod4       = 63'(x2) * 63'(epoch_utc_pkg::RCP_15625);
      st4_in.rng  = st3_ff.rng;
      st4_in.low6 = st3_ff.low6;
      st4_in.q1   = st3_ff.q1;
      st4_in.q2   = prod4[epoch_utc_pkg::SHR_15625 +: 17];
      st4_in.x2   = x2;
      st4_in.n3   = st3_ff.nlow[16:0];
   end

   always_comb begin
      rem5        = st4_ff.x2 - 31'(st4_ff.q2) * 31'(epoch_utc_pkg::DIV_15625);
      st5_in.rng  = st4_ff.rng;
      st5_in.low6 = st4_ff.low6;
      st5_in.q1   = st4_ff.q1;
      st5_in.q2   = st4_ff.q2;
      st5_in.r2   = rem5[13:0];
      st5_in.n3   = st4_ff.n3;
   end

   always_comb begin
      x3          = {st5_ff.r2, st5_ff.n3};
      prod6       = 63'(x3) * 63'(epoch_utc_pkg::RCP_15625);
      st6_in.rng  = st5_ff.rng;
      st6_in.low6 = st5_ff.low6;
      st6_in.hi   = {st5_ff.q1, st5_ff.q2};
      st6_in.q3   = prod6[epoch_utc_pkg::SHR_15625 +: 17];
      st6_in.x3   = x3;
   end

   // The last remainder, times 64 plus the six low bits, is the microsecond part.
   always_comb begin
      rem7        = st6_ff.x3 - 31'(st6_ff.q3) * 31'(epoch_utc_pkg::DIV_15625);
      quo7        = {st6_ff.hi, st6_ff.q3};
      st7_in.rng  = st6_ff.rng;
      st7_in.frac = {rem7[13:0], st6_ff.low6};
      st7_in.secs = quo7[37:0];
   end

   // Stage 8: days = seconds / 86400, done as (seconds >> 7) / 675.
   always_comb begin
      prod8       = 63'(st7_ff.secs[37:epoch_utc_pkg::DAY_LOW_BITS])
                    * 63'(epoch_utc_pkg::RCP_675);
      st8_in.rng  = st7_ff.rng;
      st8_in.frac = st7_ff.frac;
      st8_in.secs = st7_ff.secs;
      st8_in.days = prod8[epoch_utc_pkg::SHR_675 +: 22];
   end

   // Stage 9: second of the day, and the day count shifted to start at 0000-03-01.
   always_comb begin
      sod9        = st8_ff.secs - 38'(st8_ff.days) * 38'(epoch_utc_pkg::SEC_PER_DAY);
      st9_in.rng  = st8_ff.rng;
      st9_in.frac = st8_ff.frac;
      st9_in.sod  = sod9[16:0];
      st9_in.z    = st8_ff.days + epoch_utc_pkg::DAY_OFFSET;
   end

   // Stage 10: 400-year era and the hour, both by reciprocal multiply.
   always_comb begin
      prod10_era   = 45'(st9_ff.z) * 45'(epoch_utc_pkg::RCP_146097);
      prod10_hour  = 35'(st9_ff.sod) * 35'(epoch_utc_pkg::RCP_3600);
      st10_in.rng  = st9_ff.rng;
      st10_in.frac = st9_ff.frac;
      st10_in.sod  = st9_ff.sod;
      st10_in.hour = prod10_hour[epoch_utc_pkg::SHR_3600 +: 5];
      st10_in.z    = st9_ff.z;
      st10_in.era  = prod10_era[epoch_utc_pkg::SHR_146097 +: 5];
   end

   // Stage 11: day of the era and seconds left within the hour.
   always_comb begin
      doe11        = st10_ff.z - 22'(st10_ff.era) * 22'(epoch_utc_pkg::DAYS_PER_ERA);
      remh11       = st10_ff.sod - 17'(st10_ff.hour) * 17'(epoch_utc_pkg::SEC_PER_HOUR);
      st11_in.rng  = st10_ff.rng;
      st11_in.frac = st10_ff.frac;
      st11_in.hour = st10_ff.hour;
      st11_in.remh = remh11[11:0];
      st11_in.era  = st10_ff.era;
      st11_in.doe  = doe11[17:0];
   end

   // Stage 12: the leap-day corrections of the year-of-era formula, and the minute.
   // The last day of an era is the only one whose 146096 quotient is nonzero.
   always_comb begin
      prod12_a       = 37'(st11_ff.doe) * 37'(epoch_utc_pkg::RCP_1460);
      prod12_b       = 37'(st11_ff.doe) * 37'(epoch_utc_pkg::RCP_36524);
      prod12_m       = 25'(st11_ff.remh) * 25'(epoch_utc_pkg::RCP_60);
      st12_in.rng    = st11_ff.rng;
      st12_in.frac   = st11_ff.frac;
      st12_in.hour   = st11_ff.hour;
      st12_in.remh   = st11_ff.remh;
      st12_in.minute = prod12_m[epoch_utc_pkg::SHR_60 +: 6];
      st12_in.era    = st11_ff.era;
      st12_in.doe    = st11_ff.doe;
      st12_in.a      = prod12_a[epoch_utc_pkg::SHR_1460 +: 7];
      st12_in.b      = prod12_b[epoch_utc_pkg::SHR_36524 +: 3];
      st12_in.c      = (st11_ff.doe == epoch_utc_pkg::DOE_LAST);
   end

   // Stage 13: corrected day count for the year-of-era divide; second of the minute.
   always_comb begin
      sec13              = st12_ff.remh
                           - 12'(st12_ff.minute) * 12'(epoch_utc_pkg::SEC_PER_MIN);
      st13_in.rng        = st12_ff.rng;
      st13_in.tod.hour   = st12_ff.hour;
      st13_in.tod.minute = st12_ff.minute;
      st13_in.tod.second = sec13[5:0];
      st13_in.tod.micro  = st12_ff.frac;
      st13_in.era        = st12_ff.era;
      st13_in.doe        = st12_ff.doe;
      st13_in.t          = st12_ff.doe - 18'(st12_ff.a) + 18'(st12_ff.b) - 18'(st12_ff.c);
   end

   // Stage 14: year of era.
   always_comb begin
      prod14      = 37'(st13_ff.t) * 37'(epoch_utc_pkg::RCP_365);
      st14_in.rng = st13_ff.rng;
      st14_in.tod = st13_ff.tod;
      st14_in.era = st13_ff.era;
      st14_in.doe = st13_ff.doe;
      st14_in.yoe = prod14[epoch_utc_pkg::SHR_365 +: 9];
   end

   // Stage 15: pieces of the day count at the start of that year, and the
   // March-based year.
   always_comb begin
      prod15       = 19'(st14_ff.yoe) * 19'(epoch_utc_pkg::RCP_100_YOE);
      st15_in.rng  = st14_ff.rng;
      st15_in.tod  = st14_ff.tod;
      st15_in.doe  = st14_ff.doe;
      st15_in.p365 = 18'(st14_ff.yoe) * 18'(epoch_utc_pkg::DAYS_PER_YEAR);
      st15_in.y4   = st14_ff.yoe[8:2];
      st15_in.y100 = prod15[epoch_utc_pkg::SHR_100_YOE +: 2];
      st15_in.year = 14'(st14_ff.era) * 14'(epoch_utc_pkg::YEARS_PER_ERA)
                     + 14'(st14_ff.yoe);
   end

   // Stage 16: day within the March-based year.
   always_comb begin
      doy16        = st15_ff.doe
                     - (st15_ff.p365 + 18'(st15_ff.y4) - 18'(st15_ff.y100));
      st16_in.rng  = st15_ff.rng;
      st16_in.tod  = st15_ff.tod;
      st16_in.doy  = doy16[8:0];
      st16_in.year = st15_ff.year;
   end

   // Stage 17: century of the year, needed for the leap test.
   always_comb begin
      prod17       = 29'(st16_ff.year) * 29'(epoch_utc_pkg::RCP_100_YEAR);
      st17_in.rng  = st16_ff.rng;
      st17_in.tod  = st16_ff.tod;
      st17_in.doy  = st16_ff.doy;
      st17_in.year = st16_ff.year;
      st17_in.q100 = prod17[epoch_utc_pkg::SHR_100_YEAR +: 7];
   end

   // Stage 18: January and February belong to the next calendar year; the other
   // months add the 59 days of January and February plus the leap day. Past
   // year 9999 every field is zero and only the range flag is set.
   always_comb begin
      div100 = (st17_ff.year == 14'(st17_ff.q100) * 14'(epoch_utc_pkg::CENTURY));
      leap   = (st17_ff.year[1:0] == 2'd0) && (!div100 || (st17_ff.q100[1:0] == 2'd0));
      jan    = (st17_ff.doy >= epoch_utc_pkg::MARCH_TO_JAN);
      if (jan) begin
         year18 = st17_ff.year + 14'd1;
         yday18 = st17_ff.doy - epoch_utc_pkg::MARCH_TO_JAN;
      end else begin
         year18 = st17_ff.year;
         yday18 = st17_ff.doy + epoch_utc_pkg::JAN_FEB_DAYS + 9'(leap);
      end
      if (st17_ff.rng) begin
         out_in     = '0;
         out_in.rng = 1'b1;
      end else begin
         out_in.rng   = 1'b0;
         out_in.years = 13'(year18 - epoch_utc_pkg::YEAR_BASE);
         out_in.yday  = yday18 + 9'd1;
         out_in.tod   = st17_ff.tod;
      end
   end

   always_ff @(posedge clock) begin
      st1_ff  <= st1_in;
      st2_ff  <= st2_in;
      st3_ff  <= st3_in;
      st4_ff  <= st4_in;
      st5_ff  <= st5_in;
      st6_ff  <= st6_in;
      st7_ff  <= st7_in;
      st8_ff  <= st8_in;
      st9_ff  <= st9_in;
      st10_ff <= st10_in;
      st11_ff <= st11_in;
      st12_ff <= st12_in;
      st13_ff <= st13_in;
      st14_ff <= st14_in;
      st15_ff <= st15_in;
      st16_ff <= st16_in;
      st17_ff <= st17_in;
      out_ff  <= out_in;
   end

   assign busy                 = busy_ff;
   assign rsp_valid            = vld_ff[NS-1];
   assign rsp_years_since_1900 = out_ff.years;
   assign rsp_day_of_year      = out_ff.yday;
   assign rsp_hour_of_day      = out_ff.tod.hour;
   assign rsp_minute_of_hour   = out_ff.tod.minute;
   assign rsp_whole_seconds    = out_ff.tod.second;
   assign rsp_microsecond_part = out_ff.tod.micro;
   assign rsp_range_error      = out_ff.rng;

   // A wrong day quotient shows up as a second of the day outside one day.
   a_sod_in_day: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[8] && !st9_ff.rng) |-> (st9_ff.sod < epoch_utc_pkg::SEC_PER_DAY))
      else $error("second of day out of range");

   // The era split must leave a day of era below the era length.
   a_doe_in_era: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[10] && !st11_ff.rng) |-> (st11_ff.doe < epoch_utc_pkg::DAYS_PER_ERA))
      else $error("day of era out of range");

   // The year-of-era divide must leave at most 365 days in the March-based year.
   a_doy_in_year: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[15] && !st16_ff.rng) |-> (st16_ff.doy <= epoch_utc_pkg::DAYS_PER_YEAR))
      else $error("day of March-based year out of range");

   // Every result in range carries legal calendar and clock fields.
   a_fields_legal: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_range_error) |->
         ((rsp_day_of_year >= 9'd1) && (rsp_day_of_year <= 9'd366) &&
          (rsp_hour_of_day < 5'd24) && (rsp_minute_of_hour < 6'd60) &&
          (rsp_whole_seconds < 6'd60) && (rsp_microsecond_part < 20'd1000000)))
      else $error("result field out of range");

endmodule

// ----- sim/utc_fields_check.sv -----
// Result checker for the microsecond-epoch to UTC calendar converter.
// Predicts the UTC fields of every accepted item and compares each result against them.
// Depends on epoch_utc_pkg for the result layout and the year 10000 limit.
`timescale 1ns / 100ps

module utc_fields_check (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [57:0] req_epoch_microseconds,
   input  logic        rsp_valid,
   input  logic [12:0] rsp_years_since_1900,
   input  logic [8:0]  rsp_day_of_year,
   input  logic [4:0]  rsp_hour_of_day,
   input  logic [5:0]  rsp_minute_of_hour,
   input  logic [5:0]  rsp_whole_seconds,
   input  logic [19:0] rsp_microsecond_part,
   input  logic        rsp_range_error,
   output int          mismatch_count,
   output int          awaited
);

   epoch_utc_pkg::rsp_type pending_utc[$];

   // Civil calendar from a day count, with the year taken to start on March 1
   // so that the leap day falls at the end of it.
   function automatic epoch_utc_pkg::rsp_type utc_of_micros(logic [57:0] micros);
      longint unsigned secs, day_count, sec_of_day, shifted, cycle, day_in_cycle;
      longint unsigned yr_in_cycle, yr, day_from_mar, month_idx, yday;
      epoch_utc_pkg::rsp_type fields;
      fields = '0;
      if (micros >= epoch_utc_pkg::US_LIMIT) begin
         fields.rng = 1'b1;
         return fields;
      end
      secs         = micros / 1000000;
      day_count    = secs / 86400;
      sec_of_day   = secs % 86400;
      shifted      = day_count + 719468;
      cycle        = shifted / 146097;
      day_in_cycle = shifted - cycle * 146097;
      yr_in_cycle  = (day_in_cycle - day_in_cycle / 1460 + day_in_cycle / 36524
                      - day_in_cycle / 146096) / 365;
      yr           = yr_in_cycle + cycle * 400;
      day_from_mar = day_in_cycle - (365 * yr_in_cycle + yr_in_cycle / 4 - yr_in_cycle / 100);
      month_idx    = (5 * day_from_mar + 2) / 153;
      if (month_idx >= 10) begin
         yr   = yr + 1;
         yday = day_from_mar - 306;
      end else begin
         yday = day_from_mar + 59;
         if ((yr % 4 == 0 && yr % 100 != 0) || yr % 400 == 0)
            yday = yday + 1;
      end
      fields.years      = 13'(yr - 1900);
      fields.yday       = 9'(yday + 1);
      fields.tod.hour   = 5'(sec_of_day / 3600);
      fields.tod.minute = 6'((sec_of_day % 3600) / 60);
      fields.tod.second = 6'(sec_of_day % 60);
      fields.tod.micro  = 20'(micros % 1000000);
      return fields;
   endfunction

   task automatic compare_field(string label, longint unsigned want, longint unsigned got);
      if (want != got) begin
         mismatch_count++;
         $display("%0t: %s expected %0d, actual %0d", $time, label, want, got);
      end
   endtask

   always @(posedge clock) begin : watch
      epoch_utc_pkg::rsp_type got, want;
      if (!reset) begin
         if (rsp_valid === 1'b1) begin
            got = {rsp_range_error, rsp_years_since_1900, rsp_day_of_year, rsp_hour_of_day,
                   rsp_minute_of_hour, rsp_whole_seconds, rsp_microsecond_part};
            if (pending_utc.size() == 0) begin
               mismatch_count++;
               $display("%0t: result with no item waiting, expected none, actual %h",
                        $time, got);
            end else begin
               want = pending_utc.pop_front();
               compare_field("years_since_1900", want.years, got.years);
               compare_field("day_of_year", want.yday, got.yday);
               compare_field("hour_of_day", want.tod.hour, got.tod.hour);
               compare_field("minute_of_hour", want.tod.minute, got.tod.minute);
               compare_field("whole_seconds", want.tod.second, got.tod.second);
               compare_field("microsecond_part", want.tod.micro, got.tod.micro);
               compare_field("range_error", want.rng, got.rng);
            end
         end
         if (start === 1'b1 && busy === 1'b0)
            pending_utc.push_back(utc_of_micros(req_epoch_microseconds));
      end
      awaited <= pending_utc.size();
   end

endmodule

// ----- sim/epoch_microseconds_to_utc_fields_tb.sv -----
// Top of the testbench for epoch_microseconds_to_utc_fields: clock, reset, stimulus, verdict.
// Depends on epoch_utc_pkg, the converter itself and the utc_fields_check module.
`timescale 1ns / 100ps

module epoch_microseconds_to_utc_fields_tb;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic [57:0] req_epoch_microseconds = '0;
   logic        busy;
   logic        rsp_valid;
   logic [12:0] rsp_years_since_1900;
   logic [8:0]  rsp_day_of_year;
   logic [4:0]  rsp_hour_of_day;
   logic [5:0]  rsp_minute_of_hour;
   logic [5:0]  rsp_whole_seconds;
   logic [19:0] rsp_microsecond_part;
   logic        rsp_range_error;

   int mismatch_count;
   int awaited;

   // Chance, in percent, that the sender leaves a given cycle empty.
   int idle_pct;

   // The clock runs at a 12 ns period.
   always #6 clock = ~clock;

   epoch_microseconds_to_utc_fields dut (
      .clock                  (clock),
      .reset                  (reset),
      .start                  (start),
      .busy                   (busy),
      .req_epoch_microseconds (req_epoch_microseconds),
      .rsp_valid              (rsp_valid),
      .rsp_years_since_1900   (rsp_years_since_1900),
      .rsp_day_of_year        (rsp_day_of_year),
      .rsp_hour_of_day        (rsp_hour_of_day),
      .rsp_minute_of_hour     (rsp_minute_of_hour),
      .rsp_whole_seconds      (rsp_whole_seconds),
      .rsp_microsecond_part   (rsp_microsecond_part),
      .rsp_range_error        (rsp_range_error)
   );

   // The checker watches both channels on its own and keeps the expected fields.
   utc_fields_check fields_check (
      .clock                  (clock),
      .reset                  (reset),
      .start                  (start),
      .busy                   (busy),
      .req_epoch_microseconds (req_epoch_microseconds),
      .rsp_valid              (rsp_valid),
      .rsp_years_since_1900   (rsp_years_since_1900),
      .rsp_day_of_year        (rsp_day_of_year),
      .rsp_hour_of_day        (rsp_hour_of_day),
      .rsp_minute_of_hour     (rsp_minute_of_hour),
      .rsp_whole_seconds      (rsp_whole_seconds),
      .rsp_microsecond_part   (rsp_microsecond_part),
      .rsp_range_error        (rsp_range_error),
      .mismatch_count         (mismatch_count),
      .awaited                (awaited)
   );

   // Day count from the epoch to January 1 of a year. This runs the calendar in the
   // opposite direction from the checker, so stimulus built here lands exactly on
   // the day it is meant to.
   function automatic longint days_to_jan1(int year_num);
      longint y, era, yoe, doe;
      y   = year_num - 1;
      era = y / 400;
      yoe = y - era * 400;
      doe = yoe * 365 + yoe / 4 - yoe / 100 + 306;
      return era * 146097 + doe - 719468;
   endfunction

   function automatic logic [57:0] micros_at(longint days, int sod, int micro);
      return 58'((days * 86400 + sod) * 1000000 + micro);
   endfunction

   // A timestamp on or next to a calendar edge: the last day of the previous year,
   // New Year's Day, the days around February 29 and the last one or two days of
   // the year, with the time of day at midnight, just before midnight, or random.
   function automatic logic [57:0] calendar_edge_stamp();
      int year_num, offset, sod, micro;
      year_num = $urandom_range(9999, 1971);
      case ($urandom_range(5))
         0:       offset = -1;
         1:       offset = 0;
         2:       offset = 58;
         3:       offset = 59;
         4:       offset = 60;
         default: offset = $urandom_range(365, 364);
      endcase
      case ($urandom_range(2))
         0:       sod = 0;
         1:       sod = 86399;
         default: sod = $urandom_range(86399);
      endcase
      case ($urandom_range(2))
         0:       micro = 0;
         1:       micro = 999999;
         default: micro = $urandom_range(999999);
      endcase
      return micros_at(days_to_jan1(year_num) + offset, sod, micro);
   endfunction

   // Most random timestamps fall inside the calendar's range, since only those get
   // past the range check into the date arithmetic. Full-width values make every
   // input bit toggle and produce range errors; a slice sits right on the limit.
   function automatic logic [57:0] random_stamp();
      logic [63:0] wide;
      int          pick;
      wide = {$urandom, $urandom};
      pick = $urandom_range(99);
      if (pick < 55)
         return wide[57:0] % epoch_utc_pkg::US_LIMIT;
      else if (pick < 70)
         return wide[57:0];
      else if (pick < 90)
         return calendar_edge_stamp();
      else
         return epoch_utc_pkg::US_LIMIT - 58'd4000000 + 58'($urandom_range(8000000));
   endfunction

   // Offers one item and returns at the edge that accepts it. Before the item the
   // sender may leave cycles empty, so gaps land at every point of the pipeline.
   task automatic send_stamp(logic [57:0] stamp);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start                  <= 1'b1;
      req_epoch_microseconds <= stamp;
      @(posedge clock);
      while (busy)
         @(posedge clock);
   endtask

   // Stops sending until every expected result has come back.
   task automatic drain_results();
      start <= 1'b0;
      @(posedge clock);
      while (awaited != 0)
         @(posedge clock);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset    <= 1'b0;
      idle_pct = 33;

      // Directed items: the bounds of the input, whole-second and whole-day edges,
      // leap days in ordinary and 400-year leap years, the end of February in year 2100, the
      // last day of a leap year, the last instant of year 9999 and the first ones after it.
      send_stamp(58'd0);
      send_stamp(58'd1);
      send_stamp(58'd999999);
      send_stamp(58'd1000000);
      send_stamp(micros_at(0, 86399, 999999));
      send_stamp(micros_at(days_to_jan1(1971), 0, 0));
      send_stamp(micros_at(days_to_jan1(1972) + 59, 43200, 500000));
      send_stamp(micros_at(days_to_jan1(1972) + 365, 86399, 999999));
      send_stamp(micros_at(days_to_jan1(2000) + 59, 3661, 1));
      send_stamp(micros_at(days_to_jan1(2000) + 60, 0, 0));
      send_stamp(micros_at(days_to_jan1(2000) + 365, 86399, 999999));
      send_stamp(micros_at(days_to_jan1(2100) + 58, 86399, 999999));
      send_stamp(micros_at(days_to_jan1(2100) + 59, 0, 0));
      send_stamp(micros_at(days_to_jan1(2100) + 364, 45296, 789012));
      send_stamp(micros_at(days_to_jan1(2400) + 365, 86399, 999999));
      send_stamp(micros_at(days_to_jan1(9999), 0, 0));
      send_stamp(epoch_utc_pkg::US_LIMIT - 58'd1);
      send_stamp(epoch_utc_pkg::US_LIMIT);
      send_stamp(epoch_utc_pkg::US_LIMIT + 58'd1);
      send_stamp({58{1'b1}});
      send_stamp({29{2'b01}});
      send_stamp({29{2'b10}});
      drain_results();

      // Random items in three stretches: a light idle rate, a heavy one and none.
      repeat (620) send_stamp(random_stamp());
      drain_results();
      idle_pct = 45;
      repeat (620) send_stamp(random_stamp());
      drain_results();
      idle_pct = 0;
      repeat (610) send_stamp(random_stamp());
      start <= 1'b0;

      // Let the pipeline empty, then give a stray late result time to show up.
      repeat (4 * epoch_utc_pkg::NUM_STAGES) begin
         if (awaited != 0)
            @(posedge clock);
      end
      repeat (epoch_utc_pkg::NUM_STAGES + 4) @(posedge clock);

      if (mismatch_count == 0 && awaited == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // A correct run takes well under a tenth of this.
   initial begin
      #2000000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

// ----- epoch_microseconds_to_utc_fields.f -----
rtl/epoch_utc_pkg.sv
rtl/epoch_microseconds_to_utc_fields.sv
sim/utc_fields_check.sv
sim/epoch_microseconds_to_utc_fields_tb.sv
